@@ rtl/tabl_pkg.sv @@
// shared types and constants for the three-axis biquad low-pass
package tabl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int AXES     = 3;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_GAIN_COEF    = 2'd0,
        REG_FEEDBACK_ONE = 2'd1,
        REG_FEEDBACK_TWO = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
        logic                       restart;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_x;
        logic signed [SAMPLE_W-1:0] filtered_y;
        logic signed [SAMPLE_W-1:0] filtered_z;
    } t_out_beat;

endpackage

@@ rtl/three_axis_biquad_lowpass_top.sv @@
// three-axis direct-form-I second-order low-pass with APB coefficient registers
//
// Input channel i_valid/o_ready/i_in carries one x, y, z sample per beat plus a
// restart flag that zeroes all history before that sample is filtered.
// Output channel o_valid/i_ready/o_out carries the three filtered samples.
// Coefficients gain (b0 = g, b1 = 2g, b2 = g), a1 and a2 are signed Q2.16 at
// the default width and sit at APB byte addresses 0x0, 0x4 and 0x8; pready is
// tied high and reads return the sign-extended coefficient.
// A beat is captured in an input register, from which five parallel
// multipliers per axis, one adder tree, rounding and saturation produce the
// result, which lands in the output register together with the history update.
// The result is registered; throughput is one beat per cycle while the receiver
// does not stall, set by the feedback from the output history.
// When the receiver stalls, the output register holds its beat and the input
// register still takes one more beat, after which o_ready drops.
// Reset clears the coefficients, all history and both valid flags.
module three_axis_biquad_lowpass_top
    import tabl_pkg::*;
#(
    parameter int COEF_WIDTH = 18
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_in_beat            i_in,
    output logic                o_valid,
    input  logic                i_ready,
    output t_out_beat           o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int COEF_FRAC = COEF_WIDTH - 2;
    localparam int PROD_W    = SAMPLE_W + COEF_WIDTH;
    localparam int ACC_W     = PROD_W + 3;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] OUT_MAX    = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN    = -ACC_W'(2 ** (SAMPLE_W - 1));

    logic signed [COEF_WIDTH-1:0] r_gain_coef;
    logic signed [COEF_WIDTH-1:0] r_feedback_one;
    logic signed [COEF_WIDTH-1:0] r_feedback_two;

    logic signed [SAMPLE_W-1:0] r_x1 [AXES];
    logic signed [SAMPLE_W-1:0] r_x2 [AXES];
    logic signed [SAMPLE_W-1:0] r_y1 [AXES];
    logic signed [SAMPLE_W-1:0] r_y2 [AXES];

    logic       r_in_valid;
    t_in_beat   r_in;
    logic       r_out_valid;
    t_out_beat  r_out;

    logic                       advance;
    logic                       cfg_wr;
    t_reg_idx                   cfg_idx;
    logic signed [SAMPLE_W-1:0] cur_x  [AXES];
    logic signed [SAMPLE_W-1:0] hist_x1[AXES];
    logic signed [SAMPLE_W-1:0] hist_x2[AXES];
    logic signed [SAMPLE_W-1:0] hist_y1[AXES];
    logic signed [SAMPLE_W-1:0] hist_y2[AXES];
    logic signed [SAMPLE_W-1:0] n_y    [AXES];

    function automatic logic signed [SAMPLE_W-1:0] biquad(
        input logic signed [SAMPLE_W-1:0]   x,
        input logic signed [SAMPLE_W-1:0]   x1,
        input logic signed [SAMPLE_W-1:0]   x2,
        input logic signed [SAMPLE_W-1:0]   y1,
        input logic signed [SAMPLE_W-1:0]   y2,
        input logic signed [COEF_WIDTH-1:0] g,
        input logic signed [COEF_WIDTH-1:0] a1,
        input logic signed [COEF_WIDTH-1:0] a2
    );
        logic signed [PROD_W-1:0] p0;
        logic signed [PROD_W-1:0] pm;
        logic signed [PROD_W-1:0] p2;
        logic signed [PROD_W-1:0] q1;
        logic signed [PROD_W-1:0] q2;
        logic signed [ACC_W-1:0]  acc;
        logic signed [ACC_W-1:0]  shifted;
        p0 = g * x;
        pm = g * x1;
        p2 = g * x2;
        q1 = a1 * y1;
        q2 = a2 * y2;
        acc = ACC_W'(p0) + (ACC_W'(pm) <<< 1) + ACC_W'(p2)
            - ACC_W'(q1) - ACC_W'(q2) + ROUND_HALF;
        // arithmetic shift gives floor, so ties go toward plus infinity
        shifted = acc >>> COEF_FRAC;
        if (shifted > OUT_MAX) begin
            return OUT_MAX[SAMPLE_W-1:0];
        end else if (shifted < OUT_MIN) begin
            return OUT_MIN[SAMPLE_W-1:0];
        end
        return shifted[SAMPLE_W-1:0];
    endfunction

    // handshake
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // apb
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_GAIN_COEF:    prdata = APB_DW'(r_gain_coef);
            REG_FEEDBACK_ONE: prdata = APB_DW'(r_feedback_one);
            REG_FEEDBACK_TWO: prdata = APB_DW'(r_feedback_two);
            default:          prdata = '0;
        endcase
    end

    // datapath: restart masks the history seen by this sample
    assign cur_x[0] = r_in.sample_x;
    assign cur_x[1] = r_in.sample_y;
    assign cur_x[2] = r_in.sample_z;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            hist_x1[a] = r_in.restart ? '0 : r_x1[a];
            hist_x2[a] = r_in.restart ? '0 : r_x2[a];
            hist_y1[a] = r_in.restart ? '0 : r_y1[a];
            hist_y2[a] = r_in.restart ? '0 : r_y2[a];
            n_y[a] = biquad(cur_x[a], hist_x1[a], hist_x2[a], hist_y1[a], hist_y2[a],
                            r_gain_coef, r_feedback_one, r_feedback_two);
        end
    end

    // control, coefficients and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_gain_coef    <= '0;
            r_feedback_one <= '0;
            r_feedback_two <= '0;
            for (int a = 0; a < AXES; a++) begin
                r_x1[a] <= '0;
                r_x2[a] <= '0;
                r_y1[a] <= '0;
                r_y2[a] <= '0;
            end
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                for (int a = 0; a < AXES; a++) begin
                    r_x2[a] <= hist_x1[a];
                    r_x1[a] <= cur_x[a];
                    r_y2[a] <= hist_y1[a];
                    r_y1[a] <= n_y[a];
                end
            end

            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_GAIN_COEF:    r_gain_coef    <= pwdata[COEF_WIDTH-1:0];
                    REG_FEEDBACK_ONE: r_feedback_one <= pwdata[COEF_WIDTH-1:0];
                    REG_FEEDBACK_TWO: r_feedback_two <= pwdata[COEF_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out.filtered_x <= n_y[0];
            r_out.filtered_y <= n_y[1];
            r_out.filtered_z <= n_y[2];
        end
    end

endmodule

@@ test/tb.sv @@
// testbench for the three-axis biquad low-pass: coefficient writes, stream stimulus, checking
`timescale 1ns / 1ps

module tb;
    import tabl_pkg::*;

    localparam int COEF_W      = 18;
    localparam int COEF_FRAC   = COEF_W - 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 80;

    // expected filter outputs, predicted per accepted sample beat
    class biquad_scoreboard;
        logic signed [COEF_W-1:0]   gain;
        logic signed [COEF_W-1:0]   fb_one;
        logic signed [COEF_W-1:0]   fb_two;
        logic signed [SAMPLE_W-1:0] x_last[AXES];
        logic signed [SAMPLE_W-1:0] x_prev[AXES];
        logic signed [SAMPLE_W-1:0] y_last[AXES];
        logic signed [SAMPLE_W-1:0] y_prev[AXES];
        t_out_beat                  expected_q[$];
        int                         errors;

        function new();
            gain   = '0;
            fb_one = '0;
            fb_two = '0;
            errors = 0;
            clear_history();
        endfunction

        function void clear_history();
            for (int a = 0; a < AXES; a++) begin
                x_last[a] = '0;
                x_prev[a] = '0;
                y_last[a] = '0;
                y_prev[a] = '0;
            end
        endfunction

        function void set_coef(t_reg_idx idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_GAIN_COEF:    gain   = value[COEF_W-1:0];
                REG_FEEDBACK_ONE: fb_one = value[COEF_W-1:0];
                REG_FEEDBACK_TWO: fb_two = value[COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [SAMPLE_W-1:0] run_axis(int a, logic signed [SAMPLE_W-1:0] x);
            longint acc;
            longint mid;
            longint max_out;
            longint min_out;
            max_out = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
            min_out = -max_out - 1;
            mid = longint'(gain) * longint'(x_last[a]);
            acc = longint'(gain) * longint'(x) + 2 * mid
                + longint'(gain) * longint'(x_prev[a])
                - longint'(fb_one) * longint'(y_last[a])
                - longint'(fb_two) * longint'(y_prev[a])
                + (longint'(1) <<< (COEF_FRAC - 1));
            // floor after adding half: ties go up
            acc = acc >>> COEF_FRAC;
            if (acc > max_out) acc = max_out;
            if (acc < min_out) acc = min_out;
            x_prev[a] = x_last[a];
            x_last[a] = x;
            y_prev[a] = y_last[a];
            y_last[a] = acc[SAMPLE_W-1:0];
            return acc[SAMPLE_W-1:0];
        endfunction

        function void note_sample(t_in_beat b);
            t_out_beat exp_beat;
            if (b.restart) clear_history();
            exp_beat.filtered_x = run_axis(0, b.sample_x);
            exp_beat.filtered_y = run_axis(1, b.sample_y);
            exp_beat.filtered_z = run_axis(2, b.sample_z);
            expected_q.push_back(exp_beat);
        endfunction

        function void check_filtered(t_out_beat got);
            t_out_beat                  exp_beat;
            logic signed [SAMPLE_W-1:0] e[AXES];
            logic signed [SAMPLE_W-1:0] g[AXES];
            string                      axis_names;
            axis_names = "xyz";
            if (expected_q.size() == 0) begin
                $display("%0t: output beat with nothing expected, actual x=%0d y=%0d z=%0d",
                         $time, got.filtered_x, got.filtered_y, got.filtered_z);
                errors++;
                return;
            end
            exp_beat = expected_q.pop_front();
            e = '{exp_beat.filtered_x, exp_beat.filtered_y, exp_beat.filtered_z};
            g = '{got.filtered_x, got.filtered_y, got.filtered_z};
            for (int a = 0; a < AXES; a++) begin
                if (g[a] !== e[a]) begin
                    $display("%0t: filtered_%c expected %0d actual %0d",
                             $time, axis_names[a], e[a], g[a]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    t_in_beat            i_in    = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    t_out_beat           o_out;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    biquad_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;

    three_axis_biquad_lowpass_top #(
        .COEF_WIDTH(COEF_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_filtered(o_out);
            if (i_valid && o_ready) sb.note_sample(i_in);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_in_beat make_beat(logic signed [SAMPLE_W-1:0] x,
                                           logic signed [SAMPLE_W-1:0] y,
                                           logic signed [SAMPLE_W-1:0] z, bit rs);
        t_in_beat b;
        b.sample_x = x;
        b.sample_y = y;
        b.sample_z = z;
        b.restart  = rs;
        return b;
    endfunction

    // mostly full-range values, sometimes the range edges, zero or minus one
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       v = 16'sh7fff;
                1:       v = 16'sh8000;
                2:       v = '0;
                default: v = '1;
            endcase
        end else begin
            v = SAMPLE_W'($urandom());
        end
        return v;
    endfunction

    function automatic t_in_beat random_beat();
        return make_beat(pick_sample(), pick_sample(), pick_sample(),
                         ($urandom_range(19) == 0));
    endfunction

    function automatic int rand_coef();
        return int'($urandom_range(262143)) - 131072;
    endfunction

    task automatic apb_write(t_reg_idx idx, int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_coef(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_coefs(int g, int a1, int a2);
        apb_write(REG_GAIN_COEF, g);
        apb_write(REG_FEEDBACK_ONE, a1);
        apb_write(REG_FEEDBACK_TWO, a2);
    endtask

    task automatic send_sample(t_in_beat b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_in    <= random_beat();
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // drop valid and let every expected beat come out before touching registers
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // coefficients still at reset: every output is zero
        send_sample(make_beat(16'sh7fff, 16'sh8000, 16'sd1234, 1'b0));
        send_sample(make_beat(-16'sd1, 16'sh7fff, 16'sh8000, 1'b1));
        send_sample(make_beat(16'sh8000, -16'sd1, 16'sh7fff, 1'b0));
        drain();

        // unused index must leave the coefficients alone
        apb_write(REG_UNUSED, 12345);
        set_coefs(4422, -74908, 27053);
        send_sample(make_beat(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1));
        repeat (3) send_sample(make_beat(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0));
        repeat (2) send_sample(make_beat(16'sh8000, 16'sh8000, 16'sh8000, 1'b0));
        send_sample(make_beat(16'sh7fff, 16'sh8000, 16'sd0, 1'b0));
        send_sample(make_beat(16'sh8000, 16'sh7fff, -16'sd1, 1'b0));
        send_sample(make_beat(16'sd0, -16'sd1, 16'sd1, 1'b1));
        send_sample(make_beat(16'sd1, -16'sd1, 16'sd0, 1'b0));
        drain();

        // extreme coefficients drive the output into saturation
        set_coefs(131071, -131072, 131071);
        send_sample(make_beat(16'sh7fff, 16'sh8000, 16'sd100, 1'b1));
        repeat (3) send_sample(make_beat(16'sh7fff, 16'sh8000, -16'sd100, 1'b0));
        drain();
        set_coefs(-131072, 131071, -131072);
        send_sample(make_beat(16'sh8000, 16'sh7fff, -16'sd100, 1'b1));
        repeat (3) send_sample(make_beat(16'sh8000, 16'sh7fff, 16'sd100, 1'b0));
        drain();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       set_coefs(19195, 0, 11247);
                1:       set_coefs(131071, -131072, 131071);
                3:       set_coefs(-131072, 131071, -131072);
                default: set_coefs(rand_coef(), rand_coef(), rand_coef());
            endcase
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 57; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 57; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            repeat (PHASE_ITEMS) send_sample(random_beat());
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tabl_pkg.sv
rtl/three_axis_biquad_lowpass_top.sv
test/tb.sv
